[sv/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and helpers of the Playfair digraph cipher: square
// layout, letter codes, register indexes and the digraph word format.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned SqDim    = 5;
  localparam int unsigned CfgDataW = 25;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] pos_t;
  typedef logic [6:0] ascii_t;

  // Column c of a row sits at bits 5c+4..5c, so element [c] of the packed row
  typedef letter_t [SqDim-1:0] sq_row_t;
  typedef sq_row_t [SqDim-1:0] square_t;

  localparam letter_t LetterX = 5'd23;
  localparam letter_t LetterI = 5'd8;
  localparam letter_t LetterJ = 5'd9;
  localparam ascii_t  AsciiA  = 7'd65;

  // Plain alphabet without J, row 0 in the low word
  localparam square_t SquareReset = square_t'({25'd27025109, 25'd21613104,
                                               25'd16201099, 25'd10755269,
                                               25'd4294688});

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode = 3'd0,
    CfgRow0 = 3'd1,
    CfgRow1 = 3'd2,
    CfgRow2 = 3'd3,
    CfgRow3 = 3'd4,
    CfgRow4 = 3'd5
  } cfg_idx_e;

  // One digraph waiting for the square lookup
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    done;
  } pair_t;

  // Move one place along a row or column, wrapping at the square's edge
  function automatic pos_t step_pos(pos_t p, logic back);
    pos_t res;
    if (back) begin
      res = (p == 3'd0) ? 3'(SqDim - 1) : p - 3'd1;
    end else begin
      res = (p == 3'(SqDim - 1)) ? 3'd0 : p + 3'd1;
    end
    return res;
  endfunction

endpackage

[sv/playfair_digraph_cipher.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Streaming Playfair cipher over a software-loaded 5x5 square.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one byte per word with an
// end-of-text flag. Letters are folded to upper case, J to I; other bytes
// are dropped. Output channel (out_valid_o/out_ready_i) gives one digraph
// per word; message_done_o marks the last digraph of a message.
// A digraph passes through the pair register, then the output register.
// Throughput: one byte per cycle while out_ready_i is high; a byte that
// yields two digraphs (split double plus end-of-text padding) occupies the
// single lookup unit for both, so input stalls while the first one drains.
// A stalled receiver holds the output register; one more accepted byte can
// wait in the pair register, then in_ready_o drops.
// Reset: encrypt mode, plain alphabet square, no letter held, both stages
// empty. Write the configuration port only while the block is idle.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       char_code_i,
  input  logic                             end_of_text_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [6:0]                       first_letter_o,
  output logic [6:0]                       second_letter_o,
  output logic                             message_done_o
);

  // Configuration registers
  logic             mode_q;
  pfc_pkg::square_t square_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      square_q <= pfc_pkg::SquareReset;
    end else if (cfg_we_i) begin
      case (pfc_pkg::cfg_idx_e'(cfg_idx_i))
        pfc_pkg::CfgMode: mode_q      <= cfg_data_i[0];
        pfc_pkg::CfgRow0: square_q[0] <= cfg_data_i;
        pfc_pkg::CfgRow1: square_q[1] <= cfg_data_i;
        pfc_pkg::CfgRow2: square_q[2] <= cfg_data_i;
        pfc_pkg::CfgRow3: square_q[3] <= cfg_data_i;
        pfc_pkg::CfgRow4: square_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pairing state and pending digraphs
  pfc_pkg::letter_t held_q, held_d;
  logic             held_vld_q, held_vld_d;
  pfc_pkg::pair_t   slot_q [2];
  pfc_pkg::pair_t   new_pair [2];
  logic [1:0]       new_cnt;
  logic [1:0]       rem_q;
  logic             head_q;

  logic             out_vld_q;
  pfc_pkg::ascii_t  first_q, second_q;
  logic             done_q;

  logic             in_acc, can_load, load;
  logic             is_letter;
  pfc_pkg::letter_t code;

  assign can_load   = !out_vld_q || out_ready_i;
  assign load       = (rem_q != 2'd0) && can_load;
  assign in_ready_o = (rem_q == 2'd0) || (rem_q == 2'd1 && load);
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode the byte into a letter code
  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (char_code_i inside {[8'd65:8'd90]}) begin
      is_letter = 1'b1;
      code      = 5'(char_code_i - 8'd65);
    end else if (char_code_i inside {[8'd97:8'd122]}) begin
      is_letter = 1'b1;
      code      = 5'(char_code_i - 8'd97);
    end
    if (code == pfc_pkg::LetterJ) begin
      code = pfc_pkg::LetterI;
    end
  end

  // Pair letters, split doubles, pad at end of text
  always_comb begin
    held_d      = held_q;
    held_vld_d  = held_vld_q;
    new_pair[0] = '0;
    new_pair[1] = '0;
    new_cnt     = 2'd0;
    if (is_letter) begin
      if (!held_vld_q) begin
        held_d     = code;
        held_vld_d = 1'b1;
      end else if (!mode_q && held_q == code) begin
        new_pair[0] = '{first: held_q, second: pfc_pkg::LetterX, done: 1'b0};
        new_cnt     = 2'd1;
      end else begin
        new_pair[0] = '{first: held_q, second: code, done: 1'b0};
        new_cnt     = 2'd1;
        held_vld_d  = 1'b0;
      end
    end
    if (end_of_text_i && held_vld_d) begin
      if (new_cnt == 2'd0) begin
        new_pair[0] = '{first: held_d, second: pfc_pkg::LetterX, done: 1'b0};
      end else begin
        new_pair[1] = '{first: held_d, second: pfc_pkg::LetterX, done: 1'b0};
      end
      new_cnt    = new_cnt + 2'd1;
      held_vld_d = 1'b0;
    end
    if (end_of_text_i) begin
      case (new_cnt)
        2'd1:    new_pair[0].done = 1'b1;
        2'd2:    new_pair[1].done = 1'b1;
        default: ;
      endcase
    end
  end

  // Advance pairing state and the pending-digraph count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      held_vld_q <= 1'b0;
      rem_q      <= 2'd0;
      head_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        held_q     <= held_d;
        held_vld_q <= held_vld_d;
        rem_q      <= new_cnt;
        head_q     <= 1'b0;
      end else if (load) begin
        rem_q  <= rem_q - 2'd1;
        head_q <= 1'b1;
      end
    end
  end

  // Capture the digraphs of an accepted byte
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q[0] <= new_pair[0];
      slot_q[1] <= new_pair[1];
    end
  end

  // Square lookup for the digraph at the head
  pfc_pkg::pair_t  cur_pair;
  pfc_pkg::ascii_t xf_first, xf_second;

  assign cur_pair = slot_q[head_q];

  pfc_xform u_xform (
    .mode_i   (mode_q),
    .square_i (square_q),
    .pair_i   (cur_pair),
    .first_o  (xf_first),
    .second_o (xf_second)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      first_q  <= xf_first;
      second_q <= xf_second;
      done_q   <= cur_pair.done;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign first_letter_o  = first_q;
  assign second_letter_o = second_q;
  assign message_done_o  = done_q;

  // Two pending digraphs drain one per cycle while out_ready_i is high, never both at once
  a_two_pending_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd2 |=> rem_q != 2'd0)
    else $error("two pending digraphs drained in one cycle");

  // End of text leaves no letter held
  a_eot_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_text_i |=> !held_vld_q)
    else $error("letter still held after end of text");

  // Every emitted letter is at least 'A'
  a_letter_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (first_q >= pfc_pkg::AsciiA) && (second_q >= pfc_pkg::AsciiA))
    else $error("output letter below A");

endmodule

[sv/pfc_xform.sv]
// ----------------------------------------------------------------------------
// pfc_xform
// Digraph transform: locates both letters in the square and applies the
// same-row, same-column or rectangle rule, giving two ASCII letters.
// ----------------------------------------------------------------------------
module pfc_xform (
  input  logic             mode_i,
  input  pfc_pkg::square_t square_i,
  input  pfc_pkg::pair_t   pair_i,
  output pfc_pkg::ascii_t  first_o,
  output pfc_pkg::ascii_t  second_o
);

  // Find the first row-major match; a missing letter lands at row 0, column 0
  function automatic logic [5:0] locate(pfc_pkg::square_t sq, pfc_pkg::letter_t code);
    logic [5:0] pos;
    logic       found;
    pos   = '0;
    found = 1'b0;
    for (int r = 0; r < pfc_pkg::SqDim; r++) begin
      for (int c = 0; c < pfc_pkg::SqDim; c++) begin
        if (!found && sq[r][c] == code) begin
          pos   = {3'(r), 3'(c)};
          found = 1'b1;
        end
      end
    end
    return pos;
  endfunction

  pfc_pkg::pos_t    ra, ca, rb, cb;
  pfc_pkg::letter_t oa, ob;

  assign {ra, ca} = locate(square_i, pair_i.first);
  assign {rb, cb} = locate(square_i, pair_i.second);

  // Pick the rule and read the two output cells
  always_comb begin
    if (ra == rb) begin
      oa = square_i[ra][pfc_pkg::step_pos(ca, mode_i)];
      ob = square_i[rb][pfc_pkg::step_pos(cb, mode_i)];
    end else if (ca == cb) begin
      oa = square_i[pfc_pkg::step_pos(ra, mode_i)][ca];
      ob = square_i[pfc_pkg::step_pos(rb, mode_i)][cb];
    end else begin
      oa = square_i[ra][cb];
      ob = square_i[rb][ca];
    end
  end

  assign first_o  = pfc_pkg::AsciiA + {2'b00, oa};
  assign second_o = pfc_pkg::AsciiA + {2'b00, ob};

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming Playfair digraph cipher. Bytes and
// end-of-text flags are pushed through the valid/ready input channel. A
// predictor pairs the letters and looks them up in its own copy of the
// square and mode, and every digraph word is checked in order against it.
// Directed messages come first: every pairing rule, doubled letters,
// padding, case and J folding, and degenerate squares. Random messages
// then run over shuffled, raw and damaged squares in both modes. Both
// channels idle in random bursts, and one long receiver stall backs up the
// input side.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases      = 10;
  localparam int LettersPerPhase = 125;
  localparam int LongHold       = 300;
  localparam int SettleCycles   = 8;
  localparam int StuckLimit     = 2000;

  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5A;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7A;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    pfc_pkg::ascii_t first;
    pfc_pkg::ascii_t second;
    logic            done;
  } digraph_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_we      = 1'b0;
  pfc_pkg::cfg_idx_e            cfg_idx     = pfc_pkg::CfgMode;
  logic [pfc_pkg::CfgDataW-1:0] cfg_data    = '0;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic [7:0]                   char_code   = '0;
  logic                         end_of_text = 1'b0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic [6:0]                   first_letter;
  logic [6:0]                   second_letter;
  logic                         message_done;

  // Bytes waiting to be offered, and digraphs owed by the block
  text_byte_t text_q[$];
  digraph_t   owed_q[$];
  text_byte_t next_byte;
  digraph_t   want;

  // Predictor copy of configuration and pairing state
  logic             mdl_decrypt = 1'b0;
  pfc_pkg::square_t mdl_square  = pfc_pkg::SquareReset;
  pfc_pkg::letter_t held_code   = '0;
  logic             held_full   = 1'b0;

  int  send_odds = 4;
  int  recv_odds = 4;
  int  send_gap  = 0;
  int  recv_gap  = 0;
  int  hold_left = 0;
  bit  hold_req  = 1'b0;
  int  stuck     = 0;
  int  n_fail    = 0;
  int  n_bytes   = 0;
  int  n_checked = 0;
  int  n_setups  = 0;

  playfair_digraph_cipher i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .first_letter_o (first_letter),
    .second_letter_o(second_letter),
    .message_done_o (message_done)
  );

  always #5 clk_i = ~clk_i;

  // Lowest row-major position of a letter; a missing letter sits at the origin
  function automatic void find_letter(input pfc_pkg::letter_t code,
                                      output int row, output int col);
    row = 0;
    col = 0;
    for (int r = pfc_pkg::SqDim - 1; r >= 0; r--) begin
      for (int c = pfc_pkg::SqDim - 1; c >= 0; c--) begin
        if (mdl_square[r][c] == code) begin
          row = r;
          col = c;
        end
      end
    end
  endfunction

  // Apply the row, column or rectangle rule to one letter pair
  function automatic digraph_t cipher_pair(pfc_pkg::letter_t a, pfc_pkg::letter_t b);
    int               ra, ca, rb, cb, stp;
    pfc_pkg::letter_t oa, ob;
    digraph_t         d;
    stp = mdl_decrypt ? pfc_pkg::SqDim - 1 : 1;
    find_letter(a, ra, ca);
    find_letter(b, rb, cb);
    if (ra == rb) begin
      oa = mdl_square[ra][(ca + stp) % pfc_pkg::SqDim];
      ob = mdl_square[rb][(cb + stp) % pfc_pkg::SqDim];
    end else if (ca == cb) begin
      oa = mdl_square[(ra + stp) % pfc_pkg::SqDim][ca];
      ob = mdl_square[(rb + stp) % pfc_pkg::SqDim][cb];
    end else begin
      oa = mdl_square[ra][cb];
      ob = mdl_square[rb][ca];
    end
    d.first  = pfc_pkg::AsciiA + pfc_pkg::ascii_t'(oa);
    d.second = pfc_pkg::AsciiA + pfc_pkg::ascii_t'(ob);
    d.done   = 1'b0;
    return d;
  endfunction

  // Fold one accepted byte into the pairing state and owe its digraphs
  function automatic void take_byte(logic [7:0] ch, logic eot);
    pfc_pkg::letter_t code;
    logic             is_letter;
    digraph_t         res[$];
    code      = '0;
    is_letter = 1'b0;
    if (ch >= UpperA && ch <= UpperZ) begin
      code      = pfc_pkg::letter_t'(ch - UpperA);
      is_letter = 1'b1;
    end else if (ch >= LowerA && ch <= LowerZ) begin
      code      = pfc_pkg::letter_t'(ch - LowerA);
      is_letter = 1'b1;
    end
    if (is_letter && code == pfc_pkg::LetterJ) code = pfc_pkg::LetterI;
    if (is_letter) begin
      if (!held_full) begin
        held_code = code;
        held_full = 1'b1;
      end else if (!mdl_decrypt && held_code == code) begin
        // split the double with X, keep the new letter waiting
        res.push_back(cipher_pair(held_code, pfc_pkg::LetterX));
      end else begin
        res.push_back(cipher_pair(held_code, code));
        held_full = 1'b0;
      end
    end
    if (eot && held_full) begin
      res.push_back(cipher_pair(held_code, pfc_pkg::LetterX));
      held_full = 1'b0;
    end
    if (eot && res.size() > 0) res[res.size() - 1].done = 1'b1;
    foreach (res[k]) owed_q.push_back(res[k]);
  endfunction

  function automatic logic [7:0] letter_byte(int code);
    return ($urandom_range(0, 1) ? UpperA : LowerA) + 8'(code);
  endfunction

  function automatic logic [7:0] non_letter();
    logic [7:0] ch;
    do ch = 8'($urandom);
    while ((ch >= UpperA && ch <= UpperZ) || (ch >= LowerA && ch <= LowerZ));
    return ch;
  endfunction

  // Random permutation of the 25 letters without J
  function automatic pfc_pkg::square_t shuffled_square();
    pfc_pkg::letter_t pool[25];
    pfc_pkg::letter_t t;
    pfc_pkg::square_t sq;
    int               k, j;
    k = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != pfc_pkg::LetterJ) begin
        pool[k] = pfc_pkg::letter_t'(c);
        k++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < 25; i++) sq[i / pfc_pkg::SqDim][i % pfc_pkg::SqDim] = pool[i];
    return sq;
  endfunction

  function automatic void add_byte(logic [7:0] ch, logic eot);
    text_q.push_back('{ch, eot});
  endfunction

  function automatic void add_text(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], eot_last && i == s.len() - 1);
  endfunction

  // Random messages: mostly letter runs with doubles, ended by end-of-text
  function automatic void queue_messages(int n_letters);
    int   sent, len, code;
    logic tail;
    sent = 0;
    code = 0;
    while (sent < n_letters) begin
      if ($urandom_range(0, 4) == 0) begin
        add_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        len  = $urandom_range(1, 14);
        tail = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) add_byte(non_letter(), 1'b0);
          if ($urandom_range(0, 3) != 0) code = $urandom_range(0, 25);
          add_byte(letter_byte(code), k == len - 1 && !tail);
        end
        if (tail) add_byte(non_letter(), 1'b1);
        sent += len;
      end
    end
  endfunction

  task automatic write_reg(pfc_pkg::cfg_idx_e idx, logic [pfc_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  // Load mode and square while idle, then mirror them in the predictor
  task automatic load_config(logic decrypt, pfc_pkg::square_t sq);
    write_reg(pfc_pkg::CfgMode, {{(pfc_pkg::CfgDataW - 1){1'b0}}, decrypt});
    write_reg(pfc_pkg::CfgRow0, sq[0]);
    write_reg(pfc_pkg::CfgRow1, sq[1]);
    write_reg(pfc_pkg::CfgRow2, sq[2]);
    write_reg(pfc_pkg::CfgRow3, sq[3]);
    write_reg(pfc_pkg::CfgRow4, sq[4]);
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    mdl_decrypt  = decrypt;
    mdl_square   = sq;
    n_setups++;
    @(negedge clk_i);
  endtask

  // Hold until every byte is taken and every digraph returned
  task automatic settle();
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid || owed_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Driver: offer the next byte word once the previous one is taken
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      char_code   <= '0;
      end_of_text <= 1'b0;
      send_gap     = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_byte(char_code, end_of_text);
        n_bytes++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && send_odds != 0 && $urandom_range(1, send_odds) == 1)
          send_gap = $urandom_range(1, 10);
        if (send_gap > 0 || text_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          next_byte    = text_q.pop_front();
          in_valid    <= 1'b1;
          char_code   <= next_byte.ch;
          end_of_text <= next_byte.eot;
        end
      end
    end
  end

  // Monitor: check each digraph word, stall the output side at random
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap   = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected digraph: first_letter %0d second_letter %0d",
                 first_letter, second_letter);
          n_fail++;
        end else begin
          want = owed_q.pop_front();
          n_checked++;
          if (first_letter !== want.first) begin
            $error("first_letter: expected %0d, got %0d", want.first, first_letter);
            n_fail++;
          end
          if (second_letter !== want.second) begin
            $error("second_letter: expected %0d, got %0d", want.second, second_letter);
            n_fail++;
          end
          if (message_done !== want.done) begin
            $error("message_done: expected %0d, got %0d", want.done, message_done);
            n_fail++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (recv_gap == 0 && recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
          recv_gap = $urandom_range(1, 10);
        if (recv_gap > 0) begin
          recv_gap--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles with work outstanding but no word moving
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (text_q.size() == 0 && !in_valid && owed_q.size() == 0)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= StuckLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    pfc_pkg::square_t sq;
    logic             decrypt;

    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Reset square, encrypt: row, column and rectangle rules, case and J folding
    add_text("HiaFbm", 1'b0);
    // doubled letter across a dropped byte, then J pairs with the held E
    add_text("e", 1'b0);
    add_byte(8'h00, 1'b0);
    add_text("eJxx", 1'b0);
    // end on a non-letter with X held, then with nothing held
    add_byte(8'hFF, 1'b1);
    add_byte("@", 1'b1);
    add_byte("[", 1'b0);
    add_byte("{", 1'b0);
    // split double and end padding on one byte, then end completing a pair
    add_text("zZ", 1'b1);
    add_text("qj", 1'b1);
    settle();

    // Decrypt: wrap at column and row zero, doubles kept, odd letter padded
    load_config(1'b1, pfc_pkg::SquareReset);
    add_text("abafkk", 1'b0);
    add_text("z", 1'b1);
    settle();

    // Degenerate squares: every cell A so every other letter is missing, codes above the alphabet
    load_config(1'b0, '0);
    add_text("Ab", 1'b1);
    settle();
    load_config(1'b1, '1);
    add_text("c", 1'b1);
    settle();

    // Random phases over fresh squares and modes
    for (int p = 0; p < NumPhases; p++) begin
      sq = shuffled_square();
      if (p == 3) begin
        for (int r = 0; r < pfc_pkg::SqDim; r++) sq[r] = 25'($urandom);
      end
      if (p == 6) begin
        // duplicate some cells so letters go missing
        repeat (4) sq[$urandom_range(0, 4)][$urandom_range(0, 4)] =
          sq[$urandom_range(0, 4)][$urandom_range(0, 4)];
      end
      decrypt = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      load_config(decrypt, sq);
      send_odds = (p == 2 || p == NumPhases - 1) ? 0 : 4;
      recv_odds = (p == 2 || p == NumPhases - 1) ? 0 : 3;
      queue_messages(LettersPerPhase);
      // back up the output side while bytes keep coming
      if (p == 4) hold_req = 1'b1;
      settle();
    end

    if (owed_q.size() != 0) begin
      $error("%0d digraphs never arrived", owed_q.size());
      n_fail++;
    end
    $display("Summary: %0d bytes in, %0d digraphs checked over %0d mode/square loads",
             n_bytes, n_checked, n_setups);
    $display("Summary: both modes, shuffled, raw and damaged squares, long output stall");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
